/* rtl/svpa_pkg.sv */
// ----------------------------------------------------------------------------
// svpa_pkg
// Shared types and constants for the synth voice pool allocator.
// ----------------------------------------------------------------------------
package svpa_pkg;

   localparam int VOICE_COUNT  = 8;
   localparam int VIDX_W       = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int REPORT_LIMIT = 8;
   localparam int REPORT_COUNT = (VOICE_COUNT < REPORT_LIMIT) ? VOICE_COUNT : REPORT_LIMIT;

   localparam int KIND_W      = 2;
   localparam int FREQ_W      = 15;
   localparam int ENV_W       = 16;
   localparam int COEF_W      = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [ENV_W-1:0]  ENV_FREE_LIMIT = 16'd66;
   localparam logic [ENV_W-1:0]  ENV_DEAD_LIMIT = 16'd7;
   localparam logic [ENV_W-1:0]  ENV_MAX        = 16'hFFFF;
   localparam logic [COEF_W-1:0] ATTACK_RESET   = 16'd64200;
   localparam logic [COEF_W-1:0] RELEASE_RESET  = 16'd65400;

   typedef enum logic [KIND_W-1:0] {
      KIND_FRAME_BEGIN = 2'd0,
      KIND_NOTE        = 2'd1,
      KIND_FRAME_END   = 2'd2,
      KIND_TICK        = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ATTACK  = 2'd0,
      CSR_RELEASE = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_NOTE_WR
   } state_type;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [ENV_W-1:0]  env;
      logic              gate;
   } voice_type;

endpackage

/* rtl/synth_voice_pool_allocator.sv */
// ----------------------------------------------------------------------------
// synth_voice_pool_allocator
// Voice pool with note allocation, voice stealing and envelope ramping.
// ----------------------------------------------------------------------------
// An item is taken on start while busy is low: req_kind selects frame_begin,
// note, frame_end or tick, req_note_freq carries the note frequency.
// Every item makes one pass over the voice memory: one entry is read per
// cycle and the previous entry is modified and written back in the same
// cycle. A note adds a step after the pass to write the chosen voice.
// frame_begin, frame_end and tick keep busy high for the pass, a note
// for the pass and that write; a note of frequency zero is answered in
// the cycle after the transfer and busy stays low.
// Results come out on rsp_* for one cycle each, marked by rsp_strobe; a tick
// gives one result per voice as its entry is written back, rsp_last on the
// final one. The receiver cannot stall the block.
// csr_we writes the attack or release coefficient; writes are expected only
// while busy is low and no result is pending.
// Reset clears all control state and marks every voice entry as unwritten,
// which reads as zero frequency, zero envelope and clear gate.
// ----------------------------------------------------------------------------
module synth_voice_pool_allocator
   import svpa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [FREQ_W-1:0]      req_note_freq,
   output logic                   rsp_strobe,
   output logic [2:0]             rsp_voice_index,
   output logic                   rsp_assigned,
   output logic                   rsp_restart_phase,
   output logic                   rsp_gate_out,
   output logic [ENV_W-1:0]       rsp_env_out,
   output logic [FREQ_W-1:0]      rsp_freq_out,
   output logic                   rsp_last,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]      csr_data
);

   state_type state_ff, state_in;

   logic [COEF_W-1:0] attack_ff, release_ff;

   kind_type          kind_ff, kind_in;
   logic [FREQ_W-1:0] note_ff, note_in;

   logic [VIDX_W-1:0] idx_ff, idx_in;
   logic              pvalid_ff, pvalid_in;
   logic [VIDX_W-1:0] paddr_ff;

   // voice memory and per-entry written flags
   voice_type                voice_mem [VOICE_COUNT];
   voice_type                rd_q_ff;
   logic                     rd_valid_ff;
   logic [VOICE_COUNT-1:0]   valid_ff;
   logic                     rd_en;
   logic [VIDX_W-1:0]        rd_addr;
   logic                     mem_we;
   logic [VIDX_W-1:0]        mem_wa;
   voice_type                mem_wd;

   // note search results
   logic              match_found_ff, match_found_in;
   logic [VIDX_W-1:0] match_idx_ff, match_idx_in;
   logic [ENV_W-1:0]  match_env_ff, match_env_in;
   logic              free_found_ff, free_found_in;
   logic [VIDX_W-1:0] free_idx_ff, free_idx_in;
   logic [ENV_W-1:0]  free_env_ff, free_env_in;
   logic [VIDX_W-1:0] low_idx_ff, low_idx_in;
   logic [ENV_W-1:0]  low_env_ff, low_env_in;

   // result registers
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [2:0]        rsp_idx_ff, rsp_idx_in;
   logic              rsp_asg_ff, rsp_asg_in;
   logic              rsp_rst_ff, rsp_rst_in;
   logic              rsp_gate_ff, rsp_gate_in;
   logic [ENV_W-1:0]  rsp_env_ff, rsp_env_in;
   logic [FREQ_W-1:0] rsp_freq_ff, rsp_freq_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              zero_note;

   voice_type         cur;
   logic              first;
   logic              active;
   logic [COEF_W-1:0] coef;
   logic [31:0]       prod;
   logic [ENV_W:0]    attack_sum;
   logic [ENV_W-1:0]  ramped;
   logic [FREQ_W-1:0] freq_diff;
   logic [21:0]       diff_x100;
   logic [21:0]       freq_x3;
   logic              near_hit;
   logic              free_hit;
   logic              report;

   logic [VIDX_W-1:0] pick_idx;
   logic [ENV_W-1:0]  pick_env;

   assign accept    = start && (state_ff == ST_IDLE);
   assign zero_note = (req_kind == KIND_NOTE) && (req_note_freq == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !zero_note) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff == VIDX_W'(VOICE_COUNT - 1)) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = (kind_ff == KIND_NOTE) ? ST_NOTE_WR : ST_IDLE;
         end
         ST_NOTE_WR: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rd_en     = (state_ff == ST_SCAN);
      rd_addr   = idx_ff;
      pvalid_in = (state_ff == ST_SCAN);
      idx_in    = idx_ff;
      kind_in   = kind_ff;
      note_in   = note_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (accept) begin
               kind_in = kind_type'(req_kind);
               note_in = req_note_freq;
            end
         end
         ST_SCAN: begin
            if (idx_ff != VIDX_W'(VOICE_COUNT - 1)) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   // envelope ramp and note match for the entry read in the previous cycle
   always_comb begin
      cur        = rd_valid_ff ? rd_q_ff : '0;
      first      = (paddr_ff == '0);
      active     = !((cur.env < ENV_DEAD_LIMIT) && !cur.gate);
      coef       = cur.gate ? attack_ff : release_ff;
      prod       = 32'(coef) * 32'(cur.env);
      attack_sum = (ENV_W+1)'(prod[31:16]) + ((ENV_W+1)'(17'h10000) - (ENV_W+1)'(coef));
      if (cur.gate) begin
         ramped = attack_sum[ENV_W] ? ENV_MAX : attack_sum[ENV_W-1:0];
      end else begin
         ramped = prod[31:16];
      end
      freq_diff = (cur.freq > note_ff) ? (cur.freq - note_ff) : (note_ff - cur.freq);
      diff_x100 = 22'(freq_diff) * 22'd100;
      freq_x3   = 22'(note_ff) * 22'd3;
      near_hit  = (cur.freq != '0) && (diff_x100 < freq_x3);
      free_hit  = (cur.env < ENV_FREE_LIMIT) && !cur.gate;
      report    = ({1'b0, paddr_ff} < (VIDX_W+1)'(REPORT_COUNT));
   end

   // chosen voice for a note: near match, else free, else quietest
   always_comb begin
      priority if (match_found_ff) begin
         pick_idx = match_idx_ff;
         pick_env = match_env_ff;
      end else if (free_found_ff) begin
         pick_idx = free_idx_ff;
         pick_env = free_env_ff;
      end else begin
         pick_idx = low_idx_ff;
         pick_env = low_env_ff;
      end
   end

   // write-back, search update and results
   always_comb begin
      mem_we         = 1'b0;
      mem_wa         = paddr_ff;
      mem_wd         = cur;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_env_in   = match_env_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      free_env_in    = free_env_ff;
      low_idx_in     = low_idx_ff;
      low_env_in     = low_env_ff;
      rsp_strobe_in  = 1'b0;
      rsp_idx_in     = '0;
      rsp_asg_in     = 1'b0;
      rsp_rst_in     = 1'b0;
      rsp_gate_in    = 1'b0;
      rsp_env_in     = '0;
      rsp_freq_in    = '0;
      rsp_last_in    = 1'b0;

      if (accept && zero_note) begin
         rsp_strobe_in = 1'b1;
         rsp_last_in   = 1'b1;
      end

      if (pvalid_ff) begin
         unique case (kind_ff)
            KIND_FRAME_BEGIN: begin
               mem_we      = 1'b1;
               mem_wd.gate = 1'b0;
            end
            KIND_FRAME_END: begin
               mem_we = 1'b1;
               if (!cur.gate && (cur.env < ENV_DEAD_LIMIT)) begin
                  mem_wd.freq = '0;
               end
            end
            KIND_TICK: begin
               mem_we = 1'b1;
               if (active) begin
                  mem_wd.env = ramped;
               end
               rsp_strobe_in = report;
               rsp_idx_in    = 3'(paddr_ff);
               rsp_gate_in   = mem_wd.gate;
               rsp_env_in    = mem_wd.env;
               rsp_freq_in   = mem_wd.freq;
               rsp_last_in   = (paddr_ff == VIDX_W'(REPORT_COUNT - 1));
            end
            KIND_NOTE: begin
               if (first) begin
                  match_found_in = 1'b0;
                  free_found_in  = 1'b0;
               end
               if (near_hit && (first || !match_found_ff)) begin
                  match_found_in = 1'b1;
                  match_idx_in   = paddr_ff;
                  match_env_in   = cur.env;
               end
               if (free_hit && (first || !free_found_ff)) begin
                  free_found_in = 1'b1;
                  free_idx_in   = paddr_ff;
                  free_env_in   = cur.env;
               end
               if (first || (cur.env < low_env_ff)) begin
                  low_idx_in = paddr_ff;
                  low_env_in = cur.env;
               end
            end
            default: begin
               mem_we = 1'b0;
            end
         endcase
      end

      if (state_ff == ST_NOTE_WR) begin
         mem_we        = 1'b1;
         mem_wa        = pick_idx;
         mem_wd.freq   = note_ff;
         mem_wd.env    = pick_env;
         mem_wd.gate   = 1'b1;
         rsp_strobe_in = 1'b1;
         rsp_idx_in    = 3'(pick_idx);
         rsp_asg_in    = 1'b1;
         rsp_rst_in    = (pick_env < ENV_FREE_LIMIT);
         rsp_gate_in   = 1'b1;
         rsp_env_in    = pick_env;
         rsp_freq_in   = note_ff;
         rsp_last_in   = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         pvalid_ff     <= 1'b0;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         attack_ff     <= ATTACK_RESET;
         release_ff    <= RELEASE_RESET;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         pvalid_ff     <= pvalid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (mem_we) begin
            valid_ff[mem_wa] <= 1'b1;
         end
         if (csr_we) begin
            if (csr_index == CSR_ATTACK) begin
               attack_ff <= csr_data;
            end else if (csr_index == CSR_RELEASE) begin
               release_ff <= csr_data;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      note_ff        <= note_in;
      paddr_ff       <= rd_addr;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      match_env_ff   <= match_env_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      free_env_ff    <= free_env_in;
      low_idx_ff     <= low_idx_in;
      low_env_ff     <= low_env_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_asg_ff     <= rsp_asg_in;
      rsp_rst_ff     <= rsp_rst_in;
      rsp_gate_ff    <= rsp_gate_in;
      rsp_env_ff     <= rsp_env_in;
      rsp_freq_ff    <= rsp_freq_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // voice memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         voice_mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_q_ff     <= voice_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_voice_index   = rsp_idx_ff;
   assign rsp_assigned      = rsp_asg_ff;
   assign rsp_restart_phase = rsp_rst_ff;
   assign rsp_gate_out      = rsp_gate_ff;
   assign rsp_env_out       = rsp_env_ff;
   assign rsp_freq_out      = rsp_freq_ff;
   assign rsp_last          = rsp_last_ff;

   // the read of one entry never meets the write-back of the same entry
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (mem_we && rd_en) |-> (mem_wa != rd_addr))
      else $error("voice memory read and write hit the same entry");

   // a note write-back always gates the chosen voice and reports it
   a_note_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NOTE_WR) |=> (rsp_strobe && rsp_assigned && rsp_gate_out && rsp_last))
      else $error("note write without matching result");

   // assigned results belong to a note write-back only
   a_assigned_src: assert property (@(posedge clock) disable iff (reset)
      rsp_assigned |-> $past(state_ff == ST_NOTE_WR))
      else $error("assigned result outside note write-back");

   // a pass that started always reaches its final entry
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAST) |-> (pvalid_ff && (paddr_ff == VIDX_W'(VOICE_COUNT - 1))))
      else $error("pass ended before the last voice");

   // a tick's final result carries the last reported voice
   a_tick_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_last && !rsp_assigned && (rsp_voice_index != '0 || REPORT_COUNT == 1))
      |-> (rsp_voice_index == 3'(REPORT_COUNT - 1)))
      else $error("tick last flag on the wrong voice");

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the voice pool allocator. A short directed table
// is followed by framed random traffic under several coefficient settings,
// and every result is checked in order against a behavioral voice pool or,
// for the typed directed rows, against a written-out answer.
module testbench;
   import svpa_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = VOICE_COUNT + 6;
   localparam int DIRECTED_ROWS = 22;
   localparam int PHASE_ITEMS   = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam logic [FREQ_W-1:0]      FREQ_TOP     = {FREQ_W{1'b1}};

   typedef struct packed {
      logic [2:0]        voice_index;
      logic              assigned;
      logic              restart_phase;
      logic              gate_out;
      logic [ENV_W-1:0]  env_out;
      logic [FREQ_W-1:0] freq_out;
      logic              last;
   } voice_report_type;

   typedef struct packed {
      kind_type          kind;
      logic [FREQ_W-1:0] freq;
      logic              typed;
      voice_report_type  want;
   } stim_row_type;

   localparam voice_report_type ZERO_NOTE_REPORT = '{voice_index: 3'd0, assigned: 1'b0,
      restart_phase: 1'b0, gate_out: 1'b0, env_out: '0, freq_out: '0, last: 1'b1};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [KIND_W-1:0]      req_kind = '0;
   logic [FREQ_W-1:0]      req_note_freq = '0;
   logic                   rsp_strobe;
   logic [2:0]             rsp_voice_index;
   logic                   rsp_assigned;
   logic                   rsp_restart_phase;
   logic                   rsp_gate_out;
   logic [ENV_W-1:0]       rsp_env_out;
   logic [FREQ_W-1:0]      rsp_freq_out;
   logic                   rsp_last;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [COEF_W-1:0]      csr_data = '0;

   logic [FREQ_W-1:0] pool_freq [VOICE_COUNT];
   logic [ENV_W-1:0]  pool_env  [VOICE_COUNT];
   logic              pool_gate [VOICE_COUNT];
   logic [COEF_W-1:0] attack_coef;
   logic [COEF_W-1:0] release_coef;

   voice_report_type pending_reports [$];
   stim_row_type     directed_rows [DIRECTED_ROWS];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               idle_pct = 7;

   synth_voice_pool_allocator uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_note_freq     (req_note_freq),
      .rsp_strobe        (rsp_strobe),
      .rsp_voice_index   (rsp_voice_index),
      .rsp_assigned      (rsp_assigned),
      .rsp_restart_phase (rsp_restart_phase),
      .rsp_gate_out      (rsp_gate_out),
      .rsp_env_out       (rsp_env_out),
      .rsp_freq_out      (rsp_freq_out),
      .rsp_last          (rsp_last),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // voice pool model
   // ------------------------------------------------------------------
   function automatic void clear_pool();
      for (int j = 0; j < VOICE_COUNT; j++) begin
         pool_freq[j] = '0;
         pool_env[j]  = '0;
         pool_gate[j] = 1'b0;
      end
      attack_coef  = ATTACK_RESET;
      release_coef = RELEASE_RESET;
   endfunction

   function automatic logic [ENV_W-1:0] ramp_envelope(logic [ENV_W-1:0] env, logic gated);
      longint unsigned c;
      longint unsigned target;
      longint unsigned acc;
      c      = 64'(gated ? attack_coef : release_coef);
      target = gated ? 64'd65536 : 64'd0;
      acc    = (c * 64'(env) + (64'd65536 - c) * target) >> 16;
      return (acc > 64'(ENV_MAX)) ? ENV_MAX : acc[ENV_W-1:0];
   endfunction

   // near match first, then a free voice, else steal the first quietest one
   function automatic int choose_voice(logic [FREQ_W-1:0] freq);
      int unsigned f;
      int unsigned vf;
      int unsigned diff;
      int          quietest;
      f = 32'(freq);
      for (int j = 0; j < VOICE_COUNT; j++) begin
         vf   = 32'(pool_freq[j]);
         diff = (vf > f) ? vf - f : f - vf;
         if (vf > 0 && 100 * diff < 3 * f) return j;
      end
      for (int j = 0; j < VOICE_COUNT; j++)
         if (pool_env[j] < ENV_FREE_LIMIT && !pool_gate[j]) return j;
      quietest = 0;
      for (int j = 1; j < VOICE_COUNT; j++)
         if (pool_env[j] < pool_env[quietest]) quietest = j;
      return quietest;
   endfunction

   function automatic void predict_voice_reports(kind_type kind, logic [FREQ_W-1:0] freq);
      voice_report_type r;
      int               v;
      r = '0;
      case (kind)
         KIND_FRAME_BEGIN: begin
            for (int j = 0; j < VOICE_COUNT; j++) pool_gate[j] = 1'b0;
         end
         KIND_NOTE: begin
            if (freq == '0) begin
               pending_reports.push_back(ZERO_NOTE_REPORT);
            end else begin
               v = choose_voice(freq);
               r.voice_index   = v[2:0];
               r.assigned      = 1'b1;
               r.restart_phase = pool_env[v] < ENV_FREE_LIMIT;
               r.gate_out      = 1'b1;
               r.env_out       = pool_env[v];
               r.freq_out      = freq;
               r.last          = 1'b1;
               pool_freq[v] = freq;
               pool_gate[v] = 1'b1;
               pending_reports.push_back(r);
            end
         end
         KIND_FRAME_END: begin
            for (int j = 0; j < VOICE_COUNT; j++)
               if (!pool_gate[j] && pool_env[j] < ENV_DEAD_LIMIT) pool_freq[j] = '0;
         end
         default: begin
            for (int j = 0; j < VOICE_COUNT; j++)
               if (pool_gate[j] || pool_env[j] >= ENV_DEAD_LIMIT)
                  pool_env[j] = ramp_envelope(pool_env[j], pool_gate[j]);
            for (int j = 0; j < REPORT_COUNT; j++) begin
               r.voice_index = j[2:0];
               r.gate_out    = pool_gate[j];
               r.env_out     = pool_env[j];
               r.freq_out    = pool_freq[j];
               r.last        = (j == REPORT_COUNT - 1);
               pending_reports.push_back(r);
            end
         end
      endcase
   endfunction

   function automatic voice_report_type typed_note(logic [2:0] idx, logic [FREQ_W-1:0] freq);
      voice_report_type r;
      r = '0;
      r.voice_index   = idx;
      r.assigned      = 1'b1;
      r.restart_phase = 1'b1;
      r.gate_out      = 1'b1;
      r.freq_out      = freq;
      r.last          = 1'b1;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------
   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      voice_report_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_reports.size() == 0) begin
            $error("result transfer with nothing expected: voice %0d", rsp_voice_index);
            mismatch_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("voice_index", 16'(want.voice_index), 16'(rsp_voice_index));
            check_field("assigned", 16'(want.assigned), 16'(rsp_assigned));
            check_field("restart_phase", 16'(want.restart_phase), 16'(rsp_restart_phase));
            check_field("gate_out", 16'(want.gate_out), 16'(rsp_gate_out));
            check_field("env_out", want.env_out, rsp_env_out);
            check_field("freq_out", 16'(want.freq_out), 16'(rsp_freq_out));
            check_field("last", 16'(want.last), 16'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   task automatic send_item(kind_type kind, logic [FREQ_W-1:0] freq,
                            logic typed = 1'b0, voice_report_type want = '0);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      start         <= 1'b1;
      req_kind      <= kind;
      req_note_freq <= freq;
      do @(posedge clock); while (busy !== 1'b0);
      predict_voice_reports(kind, freq);
      // a written-out answer replaces the single modeled note result
      if (typed) begin
         void'(pending_reports.pop_back());
         pending_reports.push_back(want);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0 || busy !== 1'b0);
      // frame items give no result, so let any pass still running finish
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_coef(logic [CSR_INDEX_W-1:0] index, logic [COEF_W-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_ATTACK)
         attack_coef = value;
      else if (index == CSR_RELEASE)
         release_coef = value;
   endtask

   function automatic logic [FREQ_W-1:0] pick_note_freq();
      int          sel;
      int unsigned base;
      int unsigned delta;
      sel  = $urandom_range(99);
      base = 32'(pool_freq[$urandom_range(VOICE_COUNT - 1)]);
      if (sel < 4) return '0;
      if (sel < 45 && base != 0) begin
         // straddle the 3% match window around a voice already in use
         delta = base * $urandom_range(4) / 100;
         if ($urandom_range(1) == 1)
            return (base + delta > FREQ_TOP) ? FREQ_TOP : FREQ_W'(base + delta);
         return FREQ_W'(base - delta);
      end
      if (sel < 60) return FREQ_W'($urandom_range(1, 200));
      if (sel < 70) return FREQ_W'($urandom_range(30000, FREQ_TOP));
      return FREQ_W'($urandom_range(1, FREQ_TOP));
   endfunction

   // mostly whole frames: begin, a few notes, end, a few ticks; some loose items
   task automatic run_frames(int count);
      int sent;
      int notes;
      int ticks;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 85) begin
            notes = $urandom_range(1, 5);
            ticks = $urandom_range(1, 6);
            send_item(KIND_FRAME_BEGIN, FREQ_W'($urandom_range(FREQ_TOP)));
            repeat (notes) send_item(KIND_NOTE, pick_note_freq());
            send_item(KIND_FRAME_END, FREQ_W'($urandom_range(FREQ_TOP)));
            repeat (ticks) send_item(KIND_TICK, FREQ_W'($urandom_range(FREQ_TOP)));
            sent += notes + ticks + 2;
         end else begin
            send_item(kind_type'($urandom_range(3)), pick_note_freq());
            sent++;
         end
      end
   endtask

   initial begin
      clear_pool();
      directed_rows = '{
         '{KIND_TICK,        15'd0,     1'b0, '0},
         '{KIND_NOTE,        15'd0,     1'b1, ZERO_NOTE_REPORT},
         '{KIND_NOTE,        FREQ_TOP,  1'b1, typed_note(3'd0, FREQ_TOP)},
         '{KIND_NOTE,        15'd1,     1'b1, typed_note(3'd1, 15'd1)},
         '{KIND_NOTE,        15'd1000,  1'b1, typed_note(3'd2, 15'd1000)},
         '{KIND_NOTE,        15'd1020,  1'b0, '0},
         '{KIND_TICK,        15'd0,     1'b0, '0},
         '{KIND_TICK,        15'd0,     1'b0, '0},
         '{KIND_TICK,        15'd0,     1'b0, '0},
         '{KIND_NOTE,        15'd5000,  1'b0, '0},
         '{KIND_NOTE,        15'd6000,  1'b0, '0},
         '{KIND_NOTE,        15'd7000,  1'b0, '0},
         '{KIND_NOTE,        15'd8000,  1'b0, '0},
         '{KIND_NOTE,        15'd9000,  1'b0, '0},
         '{KIND_TICK,        15'd0,     1'b0, '0},
         '{KIND_NOTE,        15'd20000, 1'b0, '0},
         '{KIND_FRAME_BEGIN, FREQ_TOP,  1'b0, '0},
         '{KIND_TICK,        15'd0,     1'b0, '0},
         '{KIND_TICK,        15'd0,     1'b0, '0},
         '{KIND_FRAME_END,   15'd0,     1'b0, '0},
         '{KIND_NOTE,        15'd30000, 1'b0, '0},
         '{KIND_TICK,        15'd0,     1'b0, '0}
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].kind, directed_rows[i].freq,
                   directed_rows[i].typed, directed_rows[i].want);
      run_frames(PHASE_ITEMS);

      // zero coefficients: one tick saturates an attack and silences a release
      write_coef(CSR_ATTACK, '0);
      write_coef(CSR_RELEASE, '0);
      write_coef(CSR_SPARE_LO, COEF_W'($urandom));
      run_frames(PHASE_ITEMS);

      write_coef(CSR_ATTACK, '1);
      write_coef(CSR_RELEASE, '1);
      write_coef(CSR_SPARE_HI, COEF_W'($urandom));
      idle_pct = 0;
      run_frames(PHASE_ITEMS);
      idle_pct = 7;

      write_coef(CSR_ATTACK, COEF_W'($urandom));
      write_coef(CSR_RELEASE, COEF_W'($urandom));
      run_frames(PHASE_ITEMS);

      wait_drained();
      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
